/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, command and register codes, control characters and the
// structs that pass between the console engine and the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int OP_W       = 3;
  localparam int BYTE_W     = 8;
  localparam int FCOL_W     = 7;  // column field width on the ports
  localparam int ROW_W      = 6;  // row field width, also the internal row width
  localparam int COL_W      = 8;  // internal column width, holds columns + 1
  localparam int CELL_W     = 16; // character in the low byte, attribute above
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 3'd0,
    OP_MOVE  = 3'd1,
    OP_ATTR  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

  localparam logic [FCOL_W-1:0] RESET_COLUMNS = 7'd80;
  localparam logic [ROW_W-1:0]  RESET_ROWS    = 6'd25;

  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] ATTR_DEFAULT = 8'h07;

  typedef struct packed {
    logic [FCOL_W-1:0] columns;
    logic [ROW_W-1:0]  rows;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] char_code;
    logic [FCOL_W-1:0] target_col;
    logic [ROW_W-1:0]  target_row;
    logic [BYTE_W-1:0] attr_value;
  } cmd_t;

  typedef struct packed {
    logic [FCOL_W-1:0] cursor_col_now;
    logic [ROW_W-1:0]  cursor_row_now;
    logic [BYTE_W-1:0] cell_char;
    logic [BYTE_W-1:0] cell_attr;
    logic              did_scroll;
  } res_t;

endpackage

/* hw/rtl/tcw_cell_ram.sv */
// ----------------------------------------------------------------------------
// tcw_cell_ram: screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int DEPTH = 4000,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_r [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

/* hw/rtl/tcw_engine.sv */
// ----------------------------------------------------------------------------
// tcw_engine: command sequencer of the text console writer
// Holds the cursor and current attribute and walks the cell memory one cell
// per cycle through a shared address adder for put, read, scroll and clear.
// ----------------------------------------------------------------------------
module tcw_engine #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 50,
  parameter int AW       = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcw_pkg::cfg_t              cfg,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  tcw_pkg::cmd_t              cmd,
  output logic                       res_valid,
  input  logic                       res_take,
  output tcw_pkg::res_t              res,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
  output logic                       ram_re,
  output logic [AW-1:0]              ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata
);
  import tcw_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int SW    = AW + COL_W;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_EXEC  = 9'b000000010,
    ST_COPY  = 9'b000000100,
    ST_DRAIN = 9'b000001000,
    ST_FILL  = 9'b000010000,
    ST_WRITE = 9'b000100000,
    ST_RD    = 9'b001000000,
    ST_RDW   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [BYTE_W-1:0]  attr_r, attr_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [COL_W-1:0]   c_r, c_nxt;
  logic [ROW_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic [ROW_W-1:0]   fill_last_r, fill_last_nxt;
  logic [CELL_W-1:0]  fill_data_r, fill_data_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic               clear_mode_r, clear_mode_nxt;
  logic               wr_after_r, wr_after_nxt;
  logic               scrolled_r, scrolled_nxt;
  logic [BYTE_W-1:0]  rd_char_r, rd_char_nxt;
  logic [BYTE_W-1:0]  rd_attr_r, rd_attr_nxt;

  logic [COL_W-1:0]   cols, cols_p1, tc, cc;
  logic [ROW_W-1:0]   rows, tr, cr;
  logic [SW-1:0]      addr_sum, copy_src;
  logic [AW-1:0]      base_step;
  logic               last_col;

  // Base address of a 1-based row.
  function automatic logic [AW-1:0] row_base(input logic [ROW_W-1:0] row);
    logic [SW-1:0] prod;
    prod = SW'(row - ROW_W'(1)) * SW'(MAX_COLS);
    return prod[AW-1:0];
  endfunction

  // Screen size as used: zero counts as one, and the store bounds it.
  assign cols = (cfg.columns == '0) ? COL_W'(1) :
                (cfg.columns > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(cfg.columns);
  assign rows = (cfg.rows == '0) ? ROW_W'(1) :
                (cfg.rows > MAX_ROWS) ? ROW_W'(MAX_ROWS) : cfg.rows;
  assign cols_p1 = cols + COL_W'(1);

  assign tc = (cmd_r.target_col == '0) ? COL_W'(1) :
              (COL_W'(cmd_r.target_col) > cols) ? cols : COL_W'(cmd_r.target_col);
  assign tr = (cmd_r.target_row == '0) ? ROW_W'(1) :
              (cmd_r.target_row > rows) ? rows : cmd_r.target_row;

  // The cursor may sit outside a screen that was made smaller since.
  assign cc = (cur_col_r == '0) ? COL_W'(1) :
              (cur_col_r > cols_p1) ? cols_p1 : cur_col_r;
  assign cr = (cur_row_r == '0) ? ROW_W'(1) :
              (cur_row_r > rows) ? rows : cur_row_r;

  // Shared address unit.
  assign addr_sum  = SW'(base_r) + SW'(c_r);
  assign copy_src  = addr_sum + SW'(MAX_COLS);
  assign base_step = AW'(SW'(base_r) + SW'(MAX_COLS));
  assign last_col  = (c_r == cols - COL_W'(1));

  assign cmd_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  assign res.cursor_col_now = cur_col_r[FCOL_W-1:0];
  assign res.cursor_row_now = cur_row_r;
  assign res.cell_char      = rd_char_r;
  assign res.cell_attr      = rd_attr_r;
  assign res.did_scroll     = scrolled_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    attr_nxt       = attr_r;
    base_nxt       = base_r;
    c_nxt          = c_r;
    row_cnt_nxt    = row_cnt_r;
    fill_last_nxt  = fill_last_r;
    fill_data_nxt  = fill_data_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    clear_mode_nxt = clear_mode_r;
    wr_after_nxt   = wr_after_r;
    scrolled_nxt   = scrolled_r;
    rd_char_nxt    = rd_char_r;
    rd_attr_nxt    = rd_attr_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_sum[AW-1:0];
    ram_wdata      = fill_data_r;
    ram_re         = 1'b0;
    ram_raddr      = addr_sum[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cur_col_nxt    = cc;
        cur_row_nxt    = cr;
        scrolled_nxt   = 1'b0;
        rd_char_nxt    = '0;
        rd_attr_nxt    = '0;
        pend_nxt       = 1'b0;
        clear_mode_nxt = 1'b0;
        wr_after_nxt   = 1'b0;
        base_nxt       = '0;
        c_nxt          = '0;
        row_cnt_nxt    = '0;
        fill_last_nxt  = '0;
        fill_data_nxt  = {ATTR_DEFAULT, CH_SPACE};
        state_nxt      = ST_DONE;
        case (op_t'(cmd_r.operation))
          OP_PUT: begin
            if (cmd_r.char_code == CH_NEWLINE) begin
              if (cr >= rows) begin
                state_nxt = (rows == ROW_W'(1)) ? ST_FILL : ST_COPY;
              end else begin
                cur_row_nxt = cr + ROW_W'(1);
              end
            end else if (cmd_r.char_code == CH_RETURN) begin
              cur_col_nxt = COL_W'(1);
            end else if (cmd_r.char_code == CH_BACKSPACE) begin
              if (cc > COL_W'(1)) begin
                cur_col_nxt = cc - COL_W'(1);
              end
            end else if (cc > cols) begin
              // Pending wrap: go to column 1 of the next row first.
              cur_col_nxt = COL_W'(1);
              if (cr >= rows) begin
                wr_after_nxt = 1'b1;
                state_nxt    = (rows == ROW_W'(1)) ? ST_FILL : ST_COPY;
              end else begin
                cur_row_nxt = cr + ROW_W'(1);
                base_nxt    = row_base(cr + ROW_W'(1));
                state_nxt   = ST_WRITE;
              end
            end else begin
              base_nxt  = row_base(cr);
              c_nxt     = cc - COL_W'(1);
              state_nxt = ST_WRITE;
            end
          end
          OP_MOVE: begin
            cur_col_nxt = tc;
            cur_row_nxt = tr;
          end
          OP_ATTR: begin
            attr_nxt = cmd_r.attr_value;
          end
          OP_CLEAR: begin
            fill_data_nxt  = {attr_r, CH_SPACE};
            fill_last_nxt  = rows - ROW_W'(1);
            clear_mode_nxt = 1'b1;
            state_nxt      = ST_FILL;
          end
          OP_READ: begin
            base_nxt  = row_base(tr);
            c_nxt     = tc - COL_W'(1);
            state_nxt = ST_RD;
          end
          default: begin
          end
        endcase
      end
      ST_COPY: begin
        // Read the cell one row below while the previous one is written back.
        ram_re        = 1'b1;
        ram_raddr     = copy_src[AW-1:0];
        ram_we        = pend_r;
        ram_waddr     = pend_addr_r;
        ram_wdata     = ram_rdata;
        pend_nxt      = 1'b1;
        pend_addr_nxt = addr_sum[AW-1:0];
        if (last_col) begin
          c_nxt    = '0;
          base_nxt = base_step;
          if (row_cnt_r == rows - ROW_W'(2)) begin
            row_cnt_nxt = '0;
            state_nxt   = ST_DRAIN;
          end else begin
            row_cnt_nxt = row_cnt_r + ROW_W'(1);
          end
        end else begin
          c_nxt = c_r + COL_W'(1);
        end
      end
      ST_DRAIN: begin
        ram_we    = pend_r;
        ram_waddr = pend_addr_r;
        ram_wdata = ram_rdata;
        pend_nxt  = 1'b0;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (last_col) begin
          c_nxt = '0;
          if (row_cnt_r == fill_last_r) begin
            if (clear_mode_r) begin
              cur_col_nxt = COL_W'(1);
              cur_row_nxt = ROW_W'(1);
              state_nxt   = ST_DONE;
            end else begin
              scrolled_nxt = 1'b1;
              state_nxt    = wr_after_r ? ST_WRITE : ST_DONE;
            end
          end else begin
            row_cnt_nxt = row_cnt_r + ROW_W'(1);
            base_nxt    = base_step;
          end
        end else begin
          c_nxt = c_r + COL_W'(1);
        end
      end
      ST_WRITE: begin
        ram_we      = 1'b1;
        ram_wdata   = {attr_r, cmd_r.char_code};
        cur_col_nxt = cur_col_r + COL_W'(1);
        state_nxt   = ST_DONE;
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        rd_char_nxt = ram_rdata[BYTE_W-1:0];
        rd_attr_nxt = ram_rdata[CELL_W-1:BYTE_W];
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_col_r <= COL_W'(1);
      cur_row_r <= ROW_W'(1);
      attr_r    <= ATTR_DEFAULT;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      attr_r    <= attr_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    base_r       <= base_nxt;
    c_r          <= c_nxt;
    row_cnt_r    <= row_cnt_nxt;
    fill_last_r  <= fill_last_nxt;
    fill_data_r  <= fill_data_nxt;
    pend_addr_r  <= pend_addr_nxt;
    clear_mode_r <= clear_mode_nxt;
    wr_after_r   <= wr_after_nxt;
    scrolled_r   <= scrolled_nxt;
    rd_char_r    <= rd_char_nxt;
    rd_attr_r    <= rd_attr_nxt;
  end

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (SW'(ram_waddr) < SW'(DEPTH)))
    else $error("cell write address beyond the screen store");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("scroll reads and writes the same cell in one cycle");

  a_pend_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_COPY || state_r == ST_DRAIN))
    else $error("scroll write-back pending outside the row copy");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (cur_col_r >= COL_W'(1) && cur_col_r <= cols_p1 &&
                              cur_row_r >= ROW_W'(1) && cur_row_r <= rows))
    else $error("cursor outside the screen after a command");

  a_scroll_on_put: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && scrolled_r) |-> (cmd_r.operation == OP_PUT))
    else $error("scroll reported for a command other than put");

endmodule

/* hw/rtl/text_console_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top: text-mode console character writer
// Stream in commands, stream out cursor and cell reports, one per command.
// ----------------------------------------------------------------------------
// A command is registered on acceptance and then decoded; move, set attribute,
// carriage return, backspace and newline without scroll finish there, while a
// printed character adds a cell write and a read adds a read and a wait for
// the registered read data. A scroll copies each row up by one and blanks the
// last row (it only blanks it on a one-row screen), and a clear fills every
// cell of the screen size in use. The sequencer reads and writes the single
// cell memory one cell per cycle. The input is not ready while a command is
// in progress; a finished result waits in the output register while the next
// command is taken. The cell store is not initialized at reset: a clear must
// come before any cell is read.
module text_console_writer_top #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: char_code[7:0], target_col[14:8], target_row[20:15],
  // attr_value[28:21], zero[31:29]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // in_tuser: operation[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: cursor_col_now[6:0], cursor_row_now[12:7], cell_char[20:13],
  // cell_attr[28:21], did_scroll[29], zero[31:30]
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcw_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t              cfg_r, cfg_nxt;
  cmd_t              cmd;
  res_t              res;
  logic              res_valid, res_take;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMNS: cfg_nxt.columns = cfg_data[FCOL_W-1:0];
        REG_ROWS:    cfg_nxt.rows    = cfg_data[ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cmd.operation  = in_tuser;
  assign cmd.char_code  = in_tdata[7:0];
  assign cmd.target_col = in_tdata[14:8];
  assign cmd.target_row = in_tdata[20:15];
  assign cmd.attr_value = in_tdata[28:21];

  // The result register frees as its beat leaves, so a new one can follow.
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'b00, res.did_scroll, res.cell_attr, res.cell_char,
                       res.cursor_row_now, res.cursor_col_now};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns <= RESET_COLUMNS;
      cfg_r.rows    <= RESET_ROWS;
      out_valid_r   <= 1'b0;
    end else begin
      cfg_r         <= cfg_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tcw_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the text console writer
// Streams console commands into the block and checks every cursor and cell
// report against a behavioral screen model in the bench, or a table for
// most of the directed commands that open the run. Random commands follow over
// several screen sizes, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int MAX_COLS     = 80;
  localparam int MAX_ROWS     = 50;
  localparam int SCREEN_CELLS = MAX_COLS * MAX_ROWS;
  localparam int QUIET_LIMIT  = 20000;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 400;
  localparam int PHASES       = 7;
  localparam int PRINT_LIMIT  = 50;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct {
    cmd_t cmd;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;
  logic [2:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Model of the screen, cursor and registers as seen by accepted beats.
  logic [CELL_W-1:0] screen [SCREEN_CELLS];
  int                cur_col = 1;
  int                cur_row = 1;
  logic [BYTE_W-1:0] cur_attr = ATTR_DEFAULT;
  logic [FCOL_W-1:0] cols_reg = RESET_COLUMNS;
  logic [ROW_W-1:0]  rows_reg = RESET_ROWS;

  res_t     pending_reports [$];
  dir_row_t directed_rows [$];
  bit       tx_idle = 1'b1;
  int       items_sent = 0;
  int       reports_checked = 0;
  int       scrolls_seen = 0;
  int       cell_reads = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  res_t     got;
  res_t     want;

  logic [7:0] phase_cols [PHASES] = '{8'hFF, 8'h00, 8'd7, 8'd80, 8'd1, 8'd12, 8'd3};
  logic [7:0] phase_rows [PHASES] = '{8'hFF, 8'h00, 8'd4, 8'd1, 8'd50, 8'd6, 8'd9};
  int         phase_items [PHASES] = '{30, 120, 250, 60, 120, 250, 200};

  text_console_writer_top #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int cell_at(int col, int row);
    return (row - 1) * MAX_COLS + (col - 1);
  endfunction

  task automatic scroll_screen(input int cols, input int rows);
    for (int r = 1; r < rows; r++)
      for (int c = 1; c <= cols; c++)
        screen[cell_at(c, r)] = screen[cell_at(c, r + 1)];
    for (int c = 1; c <= cols; c++)
      screen[cell_at(c, rows)] = {ATTR_DEFAULT, CH_SPACE};
  endtask

  // Applies one command to the screen model and returns the report it causes.
  task automatic console_step(input cmd_t c, output res_t r);
    int cols, rows, tc, tr;
    logic [CELL_W-1:0] cell_word;
    cols = clamp_to(int'(cols_reg), MAX_COLS);
    rows = clamp_to(int'(rows_reg), MAX_ROWS);
    tc = clamp_to(int'(c.target_col), cols);
    tr = clamp_to(int'(c.target_row), rows);
    r = '0;
    // A screen that shrank since the last command pulls the cursor inside.
    cur_col = clamp_to(cur_col, cols + 1);
    cur_row = clamp_to(cur_row, rows);
    case (c.operation)
      OP_PUT: begin
        if (c.char_code == CH_NEWLINE) begin
          if (cur_row >= rows) begin
            scroll_screen(cols, rows);
            r.did_scroll = 1'b1;
          end else begin
            cur_row++;
          end
        end else if (c.char_code == CH_RETURN) begin
          cur_col = 1;
        end else if (c.char_code == CH_BACKSPACE) begin
          if (cur_col > 1) cur_col--;
        end else begin
          if (cur_col > cols) begin
            cur_col = 1;
            if (cur_row >= rows) begin
              scroll_screen(cols, rows);
              r.did_scroll = 1'b1;
            end else begin
              cur_row++;
            end
          end
          screen[cell_at(cur_col, cur_row)] = {cur_attr, c.char_code};
          cur_col++;
        end
      end
      OP_MOVE: begin
        cur_col = tc;
        cur_row = tr;
      end
      OP_ATTR: cur_attr = c.attr_value;
      OP_CLEAR: begin
        for (int rr = 1; rr <= rows; rr++)
          for (int cc = 1; cc <= cols; cc++)
            screen[cell_at(cc, rr)] = {cur_attr, CH_SPACE};
        cur_col = 1;
        cur_row = 1;
      end
      OP_READ: begin
        cell_word = screen[cell_at(tc, tr)];
        r.cell_char = cell_word[7:0];
        r.cell_attr = cell_word[15:8];
        cell_reads++;
      end
      default: ;
    endcase
    r.cursor_col_now = cur_col[FCOL_W-1:0];
    r.cursor_row_now = cur_row[ROW_W-1:0];
  endtask

  function automatic dir_row_t dir_row(logic [OP_W-1:0] op, logic [7:0] ch,
                                       logic [6:0] tc, logic [5:0] tr,
                                       logic [7:0] av, bit typed,
                                       logic [6:0] ecol, logic [5:0] erow,
                                       logic [7:0] echr, logic [7:0] eatr,
                                       logic escr);
    dir_row_t d;
    d.cmd   = '{operation: op, char_code: ch, target_col: tc, target_row: tr,
                attr_value: av};
    d.typed = typed;
    d.want  = '{cursor_col_now: ecol, cursor_row_now: erow, cell_char: echr,
                cell_attr: eatr, did_scroll: escr};
    return d;
  endfunction

  function automatic cmd_t next_random_cmd();
    cmd_t c;
    logic [31:0] rnd, tc, tr;
    int cols, rows, pick;
    cols = clamp_to(int'(cols_reg), MAX_COLS);
    rows = clamp_to(int'(rows_reg), MAX_ROWS);
    rnd = $urandom;
    c.char_code  = rnd[7:0];
    c.attr_value = rnd[15:8];
    c.target_col = rnd[22:16];
    c.target_row = rnd[28:23];
    // Most targets land on or just around the screen in use.
    if ($urandom_range(0, 3) != 0) begin
      tc = $urandom_range(0, cols + 1);
      tr = $urandom_range(0, rows + 1);
      c.target_col = tc[6:0];
      c.target_row = tr[5:0];
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      c.operation = OP_PUT;
      case ($urandom_range(0, 9))
        0: c.char_code = CH_NEWLINE;
        1: c.char_code = CH_RETURN;
        2: c.char_code = CH_BACKSPACE;
        default: ;
      endcase
    end else if (pick < 63) begin
      c.operation = OP_MOVE;
    end else if (pick < 70) begin
      c.operation = OP_ATTR;
    end else if (pick < 72) begin
      c.operation = OP_CLEAR;
    end else if (pick < 96) begin
      c.operation = OP_READ;
    end else begin
      tc = $urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST);
      c.operation = tc[OP_W-1:0];
    end
    return c;
  endfunction

  task automatic flag_mismatch(input string what, input int got_v, input int want_v);
    if (mismatches < PRINT_LIMIT)
      $display("tb: mismatch at report %0d: %s got %0h want %0h",
               reports_checked, what, got_v, want_v);
    mismatches++;
  endtask

  // Sends one command beat and records the report it must cause.
  task automatic issue_cmd(input cmd_t c, input bit typed, input res_t typed_res);
    res_t pred;
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.operation;
    in_tdata  <= {3'b000, c.attr_value, c.target_row, c.target_col, c.char_code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    console_step(c, pred);
    pending_reports.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_COLUMNS) cols_reg = val[FCOL_W-1:0];
    else rows_reg = val[ROW_W-1:0];
  endtask

  task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows);
    drain_reports();
    repeat (2) @(posedge clk);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rows);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic run_random(input int n, input bit clear_first);
    cmd_t c;
    res_t unused;
    unused = '0;
    for (int i = 0; i < n; i++) begin
      c = next_random_cmd();
      if (i == 0 && clear_first) c.operation = OP_CLEAR;
      if (i % 64 == 0) tx_idle = ($urandom_range(0, 1) == 1);
      // Halfway through, let the block run dry before going on.
      if (i == n / 2) drain_reports();
      issue_cmd(c, 1'b0, unused);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_rows.push_back(dir_row(OP_MOVE, 8'h00, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd1, 6'd1, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_MOVE, 8'h00, 7'd127, 6'd63, 8'h00,
                                    1'b1, 7'd80, 6'd25, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_CLEAR, 8'h00, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd1, 6'd1, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_READ, 8'h00, 7'd80, 6'd25, 8'h00,
                                    1'b1, 7'd1, 6'd1, CH_SPACE, ATTR_DEFAULT, 1'b0));
    directed_rows.push_back(dir_row(OP_ATTR, 8'h00, 7'd0, 6'd0, 8'hFF,
                                    1'b1, 7'd1, 6'd1, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_PUT, 8'h41, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd2, 6'd1, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_READ, 8'h00, 7'd1, 6'd1, 8'h00,
                                    1'b1, 7'd2, 6'd1, 8'h41, 8'hFF, 1'b0));
    directed_rows.push_back(dir_row(OP_PUT, CH_BACKSPACE, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd1, 6'd1, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_PUT, CH_BACKSPACE, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd1, 6'd1, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_MOVE, 8'h00, 7'd80, 6'd25, 8'h00,
                                    1'b1, 7'd80, 6'd25, 8'h00, 8'h00, 1'b0));
    // The last column leaves a wrap pending, which backspace undoes.
    directed_rows.push_back(dir_row(OP_PUT, 8'hFF, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd81, 6'd25, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_PUT, CH_BACKSPACE, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd80, 6'd25, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_PUT, 8'h00, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd81, 6'd25, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_PUT, 8'h5A, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd2, 6'd25, 8'h00, 8'h00, 1'b1));
    directed_rows.push_back(dir_row(OP_READ, 8'h00, 7'd80, 6'd24, 8'h00,
                                    1'b1, 7'd2, 6'd25, 8'h00, 8'hFF, 1'b0));
    directed_rows.push_back(dir_row(OP_PUT, CH_RETURN, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd1, 6'd25, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_PUT, CH_NEWLINE, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd1, 6'd25, 8'h00, 8'h00, 1'b1));
    directed_rows.push_back(dir_row(OP_MOVE, 8'h00, 7'd5, 6'd3, 8'h00,
                                    1'b1, 7'd5, 6'd3, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_PUT, CH_NEWLINE, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd5, 6'd4, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_ATTR, 8'h00, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd5, 6'd4, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_SPARE_FIRST, 8'h00, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd5, 6'd4, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_SPARE_LAST, 8'hFF, 7'd127, 6'd63, 8'hFF,
                                    1'b1, 7'd5, 6'd4, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_READ, 8'h00, 7'd80, 6'd23, 8'h00,
                                    1'b0, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_CLEAR, 8'h00, 7'd0, 6'd0, 8'h00,
                                    1'b1, 7'd1, 6'd1, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(dir_row(OP_READ, 8'h00, 7'd3, 6'd2, 8'h00,
                                    1'b1, 7'd1, 6'd1, CH_SPACE, 8'h00, 1'b0));

    foreach (directed_rows[i])
      issue_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // The first phase runs at full size and clears it all, so every cell has
    // been written before any random read.
    for (int p = 0; p < PHASES; p++) begin
      set_screen(phase_cols[p], phase_rows[p]);
      run_random(phase_items[p], p == 0);
    end

    drain_reports();
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0)
      flag_mismatch("reports never delivered", pending_reports.size(), 0);
    $display("tb: %0d commands over %0d screen sizes, %0d reports checked",
             items_sent, PHASES + 1, reports_checked);
    $display("tb: %0d scrolls and %0d cell reads, %0d mismatches",
             scrolls_seen, cell_reads, mismatches);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Result side: random back-pressure, plus one long hold that lets the
  // block fill up and stall its input.
  initial begin
    int seen;
    int gap;
    bit rx_idle;
    seen = 0;
    rx_idle = 1'b1;
    wait (rst_n);
    forever begin
      if (seen % 64 == 0) rx_idle = ($urandom_range(0, 1) == 1);
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (seen == HOLD_AFTER) gap = LONG_HOLD;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.cursor_col_now = out_tdata[6:0];
      got.cursor_row_now = out_tdata[12:7];
      got.cell_char      = out_tdata[20:13];
      got.cell_attr      = out_tdata[28:21];
      got.did_scroll     = out_tdata[29];
      if (got.did_scroll) scrolls_seen++;
      if (pending_reports.size() == 0) begin
        flag_mismatch("report with nothing pending", int'(out_tdata), 0);
      end else begin
        want = pending_reports.pop_front();
        if (got.cursor_col_now != want.cursor_col_now)
          flag_mismatch("cursor column", int'(got.cursor_col_now),
                        int'(want.cursor_col_now));
        if (got.cursor_row_now != want.cursor_row_now)
          flag_mismatch("cursor row", int'(got.cursor_row_now),
                        int'(want.cursor_row_now));
        if (got.cell_char != want.cell_char)
          flag_mismatch("cell char", int'(got.cell_char), int'(want.cell_char));
        if (got.cell_attr != want.cell_attr)
          flag_mismatch("cell attr", int'(got.cell_attr), int'(want.cell_attr));
        if (got.did_scroll != want.did_scroll)
          flag_mismatch("scroll flag", int'(got.did_scroll), int'(want.did_scroll));
      end
      reports_checked++;
    end
  end

  // A clear or scroll of the full screen is the longest legal silence.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: no beat moved for %0d cycles", quiet_cycles);
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
